/* rtl/fraction_arith_unit_defines.svh */
// Assertion macros used by the port checker.
`ifndef FRACTION_ARITH_UNIT_DEFINES_SVH
`define FRACTION_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fau_pkg.sv */
`default_nettype none

package fau_pkg;

  // Port widths of the data words
  localparam int FUNC_W = 2;
  localparam int NUM_W  = 32;
  localparam int DEN_W  = 31;
  localparam int STAT_W = 2;

  // Default operand width
  localparam int VALUE_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SUB = 2'd1;
  localparam logic [FUNC_W-1:0] FN_MUL = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DIV = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIVZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

/* rtl/fau_mul.sv */
`default_nettype none

// Registered unsigned multiplier.
module fau_mul #(
  parameter int W = 32
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   op_a,
  input  wire logic [W-1:0]   op_b,
  output logic      [2*W-1:0] prod
);

  logic [2*W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {{W{1'b0}}, op_a} * {{W{1'b0}}, op_b};
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* rtl/fau_addsub.sv */
`default_nettype none

// Shared wide add/subtract unit. In subtract mode carry high means op_a >= op_b.
module fau_addsub #(
  parameter int N = 64
) (
  input  wire logic [N-1:0] op_a,
  input  wire logic [N-1:0] op_b,
  input  wire logic         sub,
  output logic      [N-1:0] sum,
  output logic              carry
);

  logic [N-1:0] b_in;
  logic [N:0]   full;

  assign b_in  = sub ? ~op_b : op_b;
  assign full  = {1'b0, op_a} + {1'b0, b_in} + {{N{1'b0}}, sub};
  assign sum   = full[N-1:0];
  assign carry = full[N];

endmodule

`default_nettype wire

/* rtl/fraction_arith_unit.sv */
`default_nettype none

// Exact rational add, subtract, multiply and divide of two signed fractions, result
// reduced to lowest terms with a positive denominator (zero is 0/1, every error is 0/1
// with a nonzero status). One word is processed at a time: in_ready is high only while
// the unit is idle, and a finished result may wait in the output register while the
// next word is accepted. On an error the unit goes from the accept straight to the result
// stage; otherwise it runs the multiplier passes, the combine, the sign fix where needed,
// the factor-of-two and binary gcd steps and two exact divisions: the cross products go
// through one registered multiplier in three passes, and the gcd and both exact divisions
// run one step per cycle on a single 2*VALUE_WIDTH-bit add/subtract unit. The next word
// is taken in the cycle after a result is loaded.
module fraction_arith_unit #(
  parameter int VALUE_WIDTH = fau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fau_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [fau_pkg::NUM_W-1:0]     in_left_num,
  input  wire logic [fau_pkg::DEN_W-1:0]     in_left_den,
  input  wire logic [fau_pkg::NUM_W-1:0]     in_right_num,
  input  wire logic [fau_pkg::DEN_W-1:0]     in_right_den,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [fau_pkg::NUM_W-1:0]     out_result_num,
  output logic      [fau_pkg::DEN_W-1:0]     out_result_den,
  output logic      [fau_pkg::STAT_W-1:0]    out_status
);

  import fau_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int N      = 2 * W;
  localparam int BCNT_W = $clog2(N);
  localparam logic [N-1:0] LIMIT = N'(1) << (W - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_COMB = 9'b000000100,
    S_NEG  = 9'b000001000,
    S_TWO  = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Operand registers
  logic [FUNC_W-1:0] func_r;
  logic              ln_r, rn_r, resn_r;
  logic [W-1:0]      lm_r, rm_r;
  logic [W-2:0]      ld_r, rd_r;
  logic [1:0]        mcnt_r;
  logic [N-1:0]      p0_r, p1_r, p2_r;
  logic [N-1:0]      nm_r, dm_r, ga_r, gb_r, g_r, divq_r, rem_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic [STAT_W-1:0] stat_r;
  logic              out_valid_r;
  logic [NUM_W-1:0]  out_num_r;
  logic [DEN_W-1:0]  out_den_r;
  logic [STAT_W-1:0] out_stat_r;

  // Input split into sign and magnitude
  logic              in_ln, in_rn, in_err, accept;
  logic [W-1:0]      in_lraw, in_rraw, in_lm, in_rm;
  logic [W-2:0]      in_ld, in_rd;

  assign accept  = in_valid && in_ready;
  assign in_lraw = in_left_num[W-1:0];
  assign in_rraw = in_right_num[W-1:0];
  assign in_ln   = in_lraw[W-1];
  assign in_rn   = in_rraw[W-1];
  assign in_lm   = in_ln ? (~in_lraw + W'(1)) : in_lraw;
  assign in_rm   = in_rn ? (~in_rraw + W'(1)) : in_rraw;
  assign in_ld   = in_left_den[W-2:0];
  assign in_rd   = in_right_den[W-2:0];
  assign in_err  = (in_ld == '0) || (in_rd == '0) || ((in_func == FN_DIV) && (in_rm == '0));

  // Shared multiplier, fed by pass number
  logic [W-1:0] mul_a, mul_b;
  logic [N-1:0] mul_p;

  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mul_a = lm_r;
        mul_b = (func_r == FN_MUL) ? rm_r : {1'b0, rd_r};
      end
      2'd1: begin
        mul_a = rm_r;
        mul_b = {1'b0, ld_r};
      end
      default: begin
        mul_a = {1'b0, ld_r};
        mul_b = {1'b0, rd_r};
      end
    endcase
  end

  fau_mul #(.W(W)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // Shared add/subtract unit
  logic [N-1:0] au_a, au_b, au_sum;
  logic         au_sub, au_carry;
  logic         bn;
  logic [N-1:0] div_t;

  assign bn    = rn_r ^ (func_r == FN_SUB);
  assign div_t = {rem_r[N-2:0], divq_r[N-1]};

  always_comb begin
    au_a   = p0_r;
    au_b   = p1_r;
    au_sub = 1'b0;
    case (state_r)
      S_COMB: begin
        au_sub = (ln_r != bn);
      end
      S_NEG: begin
        au_a   = p1_r;
        au_b   = p0_r;
        au_sub = 1'b1;
      end
      S_GCD: begin
        au_a   = ga_r;
        au_b   = gb_r;
        au_sub = 1'b1;
      end
      S_DIVN, S_DIVD: begin
        au_a   = div_t;
        au_b   = g_r;
        au_sub = 1'b1;
      end
      default: begin
        au_sub = 1'b0;
      end
    endcase
  end

  fau_addsub #(.N(N)) u_addsub (
    .op_a  (au_a),
    .op_b  (au_b),
    .sub   (au_sub),
    .sum   (au_sum),
    .carry (au_carry)
  );

  // Final range check and sign restore
  logic         ovf, out_free, div_last, is_mul_div;
  logic [W-1:0] numv;

  assign ovf        = (|dm_r[N-1:W-1]) || (resn_r ? (nm_r > LIMIT) : (nm_r >= LIMIT));
  assign numv       = resn_r ? (~nm_r[W-1:0] + W'(1)) : nm_r[W-1:0];
  assign out_free   = !out_valid_r || out_ready;
  assign div_last   = (bcnt_r == BCNT_W'(N - 1));
  assign is_mul_div = (func_r == FN_MUL) || (func_r == FN_DIV);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = in_err ? S_DONE : S_MUL;
      end
      S_MUL: begin
        if (mcnt_r == 2'd3) state_nxt = S_COMB;
      end
      S_COMB: begin
        if (!is_mul_div && (ln_r != bn) && !au_carry) state_nxt = S_NEG;
        else state_nxt = S_TWO;
      end
      S_NEG: begin
        state_nxt = S_TWO;
      end
      S_TWO: begin
        if (nm_r == '0) state_nxt = S_DONE;
        else if (nm_r[0] || dm_r[0]) state_nxt = S_GCD;
      end
      S_GCD: begin
        if (ga_r == '0) state_nxt = S_DIVN;
      end
      S_DIVN: begin
        if (div_last) state_nxt = S_DIVD;
      end
      S_DIVD: begin
        if (div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_r <= in_func;
          ln_r   <= in_ln;
          rn_r   <= in_rn;
          lm_r   <= in_lm;
          rm_r   <= in_rm;
          ld_r   <= in_ld;
          rd_r   <= in_rd;
          mcnt_r <= 2'd0;
          nm_r   <= '0;
          dm_r   <= N'(1);
          resn_r <= 1'b0;
          stat_r <= in_err ? ST_DIVZERO : ST_OK;
        end
      end
      S_MUL: begin
        mcnt_r <= mcnt_r + 2'd1;
        case (mcnt_r)
          2'd1:    p0_r <= mul_p;
          2'd2:    p1_r <= mul_p;
          2'd3:    p2_r <= mul_p;
          default: p2_r <= p2_r;
        endcase
      end
      S_COMB: begin
        dm_r <= (func_r == FN_DIV) ? p1_r : p2_r;
        if (is_mul_div) begin
          nm_r   <= p0_r;
          resn_r <= ln_r ^ rn_r;
        end else begin
          nm_r   <= au_sum;
          resn_r <= ((ln_r != bn) && !au_carry) ? bn : ln_r;
        end
      end
      S_NEG: begin
        nm_r <= au_sum;
      end
      S_TWO: begin
        // strip common factors of two, then start the odd gcd
        if (nm_r == '0) begin
          dm_r   <= N'(1);
          resn_r <= 1'b0;
        end else if (!nm_r[0] && !dm_r[0]) begin
          nm_r <= nm_r >> 1;
          dm_r <= dm_r >> 1;
        end else begin
          ga_r <= nm_r;
          gb_r <= dm_r;
        end
      end
      S_GCD: begin
        if (ga_r == '0) begin
          g_r    <= gb_r;
          divq_r <= nm_r;
          rem_r  <= '0;
          bcnt_r <= '0;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (au_carry) begin
          ga_r <= au_sum;
        end else begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end
      end
      S_DIVN: begin
        // restoring division, one quotient bit a cycle
        if (div_last) begin
          nm_r   <= {divq_r[N-2:0], au_carry};
          divq_r <= dm_r;
          rem_r  <= '0;
          bcnt_r <= '0;
        end else begin
          rem_r  <= au_carry ? au_sum : div_t;
          bcnt_r <= bcnt_r + BCNT_W'(1);
          divq_r <= {divq_r[N-2:0], au_carry};
        end
      end
      S_DIVD: begin
        rem_r  <= au_carry ? au_sum : div_t;
        bcnt_r <= bcnt_r + BCNT_W'(1);
        divq_r <= {divq_r[N-2:0], au_carry};
        if (div_last) dm_r <= {divq_r[N-2:0], au_carry};
      end
      S_DONE: begin
        if (out_free) begin
          if (stat_r != ST_OK) begin
            out_num_r  <= '0;
            out_den_r  <= DEN_W'(1);
            out_stat_r <= stat_r;
          end else if (ovf) begin
            out_num_r  <= '0;
            out_den_r  <= DEN_W'(1);
            out_stat_r <= ST_OVERFLOW;
          end else begin
            out_num_r  <= NUM_W'(numv);
            out_den_r  <= DEN_W'(dm_r[W-2:0]);
            out_stat_r <= ST_OK;
          end
        end
      end
      default: begin
        mcnt_r <= mcnt_r;
      end
    endcase
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_result_num = out_num_r;
  assign out_result_den = out_den_r;
  assign out_status     = out_stat_r;

endmodule

`default_nettype wire

/* rtl/fau_checker.sv */
`default_nettype none

`include "fraction_arith_unit_defines.svh"

// Port-level checks on the fraction unit.
module fau_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [fau_pkg::NUM_W-1:0]  out_result_num,
  input wire logic [fau_pkg::DEN_W-1:0]  out_result_den,
  input wire logic [fau_pkg::STAT_W-1:0] out_status
);

  import fau_pkg::*;

  // one word in flight: busy right after an accept
  `FAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted a word while busy")

  // error results are always 0/1
  `FAU_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_result_num == '0) && (out_result_den == DEN_W'(1)), "error result is not 0/1")

  // denominator is never zero
  `FAU_ASSERT_IMPL(a_den_pos, clk, rst_n, out_valid, out_result_den != '0, "zero denominator on output")

  // no undefined status code
  `FAU_ASSERT_IMPL(a_stat_code, clk, rst_n, out_valid, (out_status == ST_OK) || (out_status == ST_DIVZERO) || (out_status == ST_OVERFLOW), "undefined status code")

  // a stalled result stays put
  `FAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_num) && $stable(out_result_den), "stalled result changed")

endmodule

bind fraction_arith_unit fau_checker u_fau_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_result_num (out_result_num),
  .out_result_den (out_result_den),
  .out_status     (out_status)
);

`default_nettype wire

/* dv/fraction_result_checker.sv */
`default_nettype none

// Watches both channels of the fraction unit, predicts each result from the
// accepted input word and compares it with what comes out, in order.
module fraction_result_checker
  import fau_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [NUM_W-1:0]  in_left_num,
  input  wire logic [DEN_W-1:0]  in_left_den,
  input  wire logic [NUM_W-1:0]  in_right_num,
  input  wire logic [DEN_W-1:0]  in_right_den,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [NUM_W-1:0]  out_result_num,
  input  wire logic [DEN_W-1:0]  out_result_den,
  input  wire logic [STAT_W-1:0] out_status,
  output int                     fail_count,
  output int                     pending,
  output int                     words_checked,
  output int                     zero_div_seen,
  output int                     overflow_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [STAT_W-1:0] status;
  } fraction_t;

  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

  fraction_t pending_fractions[$];

  // Exact rational result in lowest terms, or 0/1 with an error status
  function automatic fraction_t predict_fraction(
    input logic [FUNC_W-1:0] op,
    input logic [NUM_W-1:0]  a_num,
    input logic [DEN_W-1:0]  a_den,
    input logic [NUM_W-1:0]  b_num,
    input logic [DEN_W-1:0]  b_den
  );
    fraction_t   res;
    logic        a_neg, b_neg, b_eff_neg, q_neg;
    logic [63:0] a_mag, b_mag, a_d, b_d, cross_a, cross_b, n_mag, d_mag;
    logic [63:0] x, y, t;
    res.num    = '0;
    res.den    = 31'd1;
    res.status = ST_OK;
    q_neg      = 1'b0;
    a_neg      = a_num[NUM_W-1];
    b_neg      = b_num[NUM_W-1];
    a_mag      = {32'd0, (a_neg ? (~a_num + 32'd1) : a_num)};
    b_mag      = {32'd0, (b_neg ? (~b_num + 32'd1) : b_num)};
    a_d        = {33'd0, a_den};
    b_d        = {33'd0, b_den};

    if (a_d == 64'd0 || b_d == 64'd0 || (op == FN_DIV && b_mag == 64'd0)) begin
      res.status = ST_DIVZERO;
      return res;
    end

    // cross products at double width
    case (op)
      FN_ADD, FN_SUB: begin
        cross_a   = a_mag * b_d;
        cross_b   = b_mag * a_d;
        b_eff_neg = (op == FN_SUB) ? !b_neg : b_neg;
        if (a_neg == b_eff_neg) begin
          n_mag = cross_a + cross_b;
          q_neg = a_neg;
        end else if (cross_a >= cross_b) begin
          n_mag = cross_a - cross_b;
          q_neg = a_neg;
        end else begin
          n_mag = cross_b - cross_a;
          q_neg = b_eff_neg;
        end
        d_mag = a_d * b_d;
      end
      FN_MUL: begin
        n_mag = a_mag * b_mag;
        d_mag = a_d * b_d;
        q_neg = a_neg ^ b_neg;
      end
      default: begin
        n_mag = a_mag * b_d;
        d_mag = a_d * b_mag;
        q_neg = a_neg ^ b_neg;
      end
    endcase

    // zero always comes out as 0/1
    if (n_mag == 64'd0) begin
      return res;
    end

    // Euclid
    x = n_mag;
    y = d_mag;
    while (x != 64'd0) begin
      t = y % x;
      y = x;
      x = t;
    end
    n_mag = n_mag / y;
    d_mag = d_mag / y;

    if (d_mag > POS_LIMIT || n_mag > (q_neg ? NEG_LIMIT : POS_LIMIT)) begin
      res.status = ST_OVERFLOW;
      return res;
    end
    res.num = q_neg ? (~n_mag[31:0] + 32'd1) : n_mag[31:0];
    res.den = d_mag[30:0];
    return res;
  endfunction

  // Input side queues a prediction, output side checks against the oldest one
  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      pending_fractions.delete();
      fail_count    = 0;
      pending       = 0;
      words_checked = 0;
      zero_div_seen = 0;
      overflow_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_fractions.push_back(predict_fraction(in_func, in_left_num, in_left_den,
                                                     in_right_num, in_right_den));
      end
      if (out_valid && out_ready) begin
        if (pending_fractions.size() == 0) begin
          $display("%0t: result word %h/%h status %h with nothing outstanding",
                   $time, out_result_num, out_result_den, out_status);
          fail_count++;
        end else begin
          want = pending_fractions.pop_front();
          words_checked++;
          if (out_status == ST_DIVZERO) zero_div_seen++;
          if (out_status == ST_OVERFLOW) overflow_seen++;
          if (out_result_num !== want.num) begin
            $display("%0t: result_num expected %h actual %h", $time, want.num, out_result_num);
            fail_count++;
          end
          if (out_result_den !== want.den) begin
            $display("%0t: result_den expected %h actual %h", $time, want.den, out_result_den);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %h actual %h", $time, want.status, out_status);
            fail_count++;
          end
        end
      end
      pending = pending_fractions.size();
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;
  import fau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RAND_WORDS  = 1830;
  localparam int          QUIET_TAIL  = 150;
  localparam int          HOLD_AT     = 400;
  localparam int          HOLD_CYCLES = 2000;
  localparam int          DRAIN       = 400;
  localparam int          CYCLE_LIMIT = 6_000_000;
  localparam logic [31:0] NUM_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] NUM_MIN     = 32'h8000_0000;
  localparam logic [30:0] DEN_MAX     = 31'h7FFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [NUM_W-1:0]  in_left_num;
  logic [DEN_W-1:0]  in_left_den;
  logic [NUM_W-1:0]  in_right_num;
  logic [DEN_W-1:0]  in_right_den;
  logic              out_valid;
  logic              out_ready;
  logic [NUM_W-1:0]  out_result_num;
  logic [DEN_W-1:0]  out_result_den;
  logic [STAT_W-1:0] out_status;

  int          fail_count;
  int          pending;
  int          words_checked;
  int          zero_div_seen;
  int          overflow_seen;
  int          words_sent;
  int unsigned gap_pct;
  int unsigned cycle_count;
  bit          quiet_tail;
  bit          long_hold_done;

  fraction_arith_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_left_num   (in_left_num),
    .in_left_den   (in_left_den),
    .in_right_num  (in_right_num),
    .in_right_den  (in_right_den),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_num(out_result_num),
    .out_result_den(out_result_den),
    .out_status    (out_status)
  );

  fraction_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_left_num   (in_left_num),
    .in_left_den   (in_left_den),
    .in_right_num  (in_right_num),
    .in_right_den  (in_right_den),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_num(out_result_num),
    .out_result_den(out_result_den),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .zero_div_seen (zero_div_seen),
    .overflow_seen (overflow_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  // Offer one word, with an optional idle burst ahead of it
  task automatic send_word(
    input logic [FUNC_W-1:0] op,
    input logic [NUM_W-1:0]  a_num,
    input logic [DEN_W-1:0]  a_den,
    input logic [NUM_W-1:0]  b_num,
    input logic [DEN_W-1:0]  b_den
  );
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(99, 0) < gap_pct) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_func      <= op;
    in_left_num  <= a_num;
    in_left_den  <= a_den;
    in_right_num <= b_num;
    in_right_den <= b_den;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Numerator by magnitude class: small, 16-bit, full range, edge values
  function automatic logic [NUM_W-1:0] pick_num(input int unsigned span);
    case (span)
      0:       return $urandom_range(128, 0) - 64;
      1:       return $urandom_range(65535, 0) - 32768;
      2:       return $urandom;
      default: begin
        case ($urandom_range(4, 0))
          0:       return NUM_MAX;
          1:       return NUM_MIN;
          2:       return '1;
          3:       return 32'd1;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [DEN_W-1:0] pick_den(input int unsigned span);
    if ($urandom_range(59, 0) == 0) return '0;
    case (span)
      0:       return DEN_W'($urandom_range(64, 1));
      1:       return DEN_W'($urandom_range(65535, 1));
      2:       return DEN_W'($urandom_range(DEN_MAX, 1));
      default: return $urandom_range(1, 0) ? DEN_MAX : 31'd1;
    endcase
  endfunction

  function automatic int unsigned pick_span();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 45) return 0;
    if (roll < 65) return 1;
    if (roll < 90) return 2;
    return 3;
  endfunction

  // Result side: random stall bursts, one long hold-off to back up the unit
  initial begin : result_sink
    int unsigned stall_pct;
    int unsigned mode_left;
    stall_pct = 0;
    mode_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(200, 40);
        case ($urandom_range(2, 0))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 50;
        endcase
      end
      mode_left--;
      if (!long_hold_done && words_sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(99, 0) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(9, 1) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [FUNC_W-1:0] op;
    logic [NUM_W-1:0]  a_num, b_num;
    int unsigned       a_span, b_span;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FN_ADD;
    in_left_num    = '0;
    in_left_den    = 31'd1;
    in_right_num   = '0;
    in_right_den   = 31'd1;
    out_ready      = 1'b0;
    words_sent     = 0;
    gap_pct        = 0;
    quiet_tail     = 1'b0;
    long_hold_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every operation, field extremes, zero divisors, overflow
    send_word(FN_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_word(FN_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
    send_word(FN_MUL, NUM_MIN, 31'd1, 32'd1, 31'd1);
    send_word(FN_MUL, NUM_MIN, 31'd1, '1, 31'd1);
    send_word(FN_DIV, 32'd1, 31'd1, '0, 31'd5);
    send_word(FN_ADD, 32'd1, '0, 32'd1, 31'd1);
    send_word(FN_SUB, 32'd1, 31'd1, 32'd1, '0);
    send_word(FN_DIV, '0, '0, '0, '0);
    send_word(FN_ADD, NUM_MAX, 31'd1, 32'd1, 31'd1);
    send_word(FN_MUL, 32'd1, DEN_MAX, 32'd1, 31'd2);
    send_word(FN_DIV, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
    send_word(FN_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
    send_word(FN_SUB, NUM_MIN, 31'd1, NUM_MAX, 31'd1);
    send_word(FN_DIV, '0, 31'd7, 32'd3, 31'd4);
    send_word(FN_MUL, '0, 31'd1, '0, 31'd1);
    send_word(FN_DIV, 32'd6, 31'd4, -32'sd3, 31'd8);
    send_word(FN_ADD, -32'sd1, 31'd3, -32'sd1, 31'd6);
    send_word(FN_MUL, NUM_MAX, DEN_MAX, NUM_MAX, 31'd1);
    send_word(FN_DIV, NUM_MAX, 31'd1, 32'd1, DEN_MAX);
    send_word(FN_SUB, '0, DEN_MAX, NUM_MIN, DEN_MAX);
    send_word(FN_DIV, 32'd5, 31'd1, NUM_MIN, 31'd1);
    send_word(FN_MUL, 32'd12, 31'd35, -32'sd14, 31'd9);
    send_word(FN_ADD, '1, DEN_MAX, '1, DEN_MAX);

    // Random words, pacing mode reshuffled every few dozen
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(2, 0))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      if (i >= RAND_WORDS - QUIET_TAIL) quiet_tail = 1'b1;
      op     = FUNC_W'($urandom_range(3, 0));
      a_span = pick_span();
      b_span = ($urandom_range(1, 0) != 0) ? a_span : pick_span();
      a_num  = ($urandom_range(19, 0) == 0) ? '0 : pick_num(a_span);
      b_num  = ($urandom_range(19, 0) == 0) ? '0 : pick_num(b_span);
      send_word(op, a_num, pick_den(a_span), b_num, pick_den(b_span));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the outstanding results, then let the bench idle before the summary
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("%0d words sent, %0d results checked (%0d zero divisor, %0d overflow)",
             words_sent, words_checked, zero_div_seen, overflow_seen);
    $display("random pacing on both sides plus a %0d-cycle result hold-off", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
